@@ rtl/positional_list_insert_delete_macros.svh @@
// ----------------------------------------------------------------------------
// positional_list_insert_delete_macros
// Assertion macros for the positional list store.
// ----------------------------------------------------------------------------
// clocked on clk_i and disabled while rst_ni is low
`ifndef POSITIONAL_LIST_INSERT_DELETE_MACROS_SVH
`define POSITIONAL_LIST_INSERT_DELETE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PLI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define PLI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PLI_ASSERT_IMP(lbl, ante, cons, msg)
`define PLI_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

@@ rtl/pli_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pli_pkg
// Types and codes shared by the positional list store modules.
// ----------------------------------------------------------------------------
package pli_pkg;

  // index width that covers every supported depth, count included
  localparam int unsigned IdxW = 7;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_DUMP   = 2'd2;
  // no effect and no response
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BADPOS = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_EMPTY  = 2'd3;

  typedef enum logic {
    FSM_IDLE,
    FSM_DUMP
  } fsm_e;

  typedef enum logic [1:0] {
    SH_HOLD,
    SH_INS,
    SH_DEL,
    SH_ROT
  } shift_e;

  typedef struct packed {
    logic [1:0]         op;
    logic [4:0]         position;
    logic signed [31:0] item_value;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] element;
    logic               last_flag;
  } rsp_t;

  typedef struct packed {
    shift_e             kind;
    logic [IdxW-1:0]    pos;
    logic [IdxW-1:0]    cnt;
    logic signed [31:0] value;
  } cmd_t;

endpackage

@@ rtl/pli_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pli_cell
// One slot of the list: holds an entry and takes from its neighbors on shifts.
// ----------------------------------------------------------------------------
module pli_cell import pli_pkg::*; #(
  parameter int unsigned IDX = 0
) (
  input  logic               clk_i,
  input  cmd_t               cmd_i,
  input  logic signed [31:0] left_i,
  input  logic signed [31:0] right_i,
  input  logic signed [31:0] head_i,
  output logic signed [31:0] data_o
);

  localparam logic [IdxW-1:0] MyIdx  = IdxW'(IDX);
  localparam logic [IdxW-1:0] NxtIdx = IdxW'(IDX + 1);

  logic signed [31:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    case (cmd_i.kind)
      SH_INS: begin
        if (MyIdx == cmd_i.pos) begin
          data_d = cmd_i.value;
        end else if (MyIdx > cmd_i.pos) begin
          data_d = left_i;
        end
      end
      SH_DEL: begin
        if (MyIdx >= cmd_i.pos) begin
          data_d = right_i;
        end
      end
      SH_ROT: begin
        // rotate the occupied prefix, head wraps to the last held slot
        if (NxtIdx < cmd_i.cnt) begin
          data_d = right_i;
        end else if (NxtIdx == cmd_i.cnt) begin
          data_d = head_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

@@ rtl/pli_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pli_ctrl
// Request decode, entry count, dump sequencing and the response register.
// ----------------------------------------------------------------------------
`include "positional_list_insert_delete_macros.svh"

module pli_ctrl import pli_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  req_t               in_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output rsp_t               out_rsp_o,
  input  logic signed [31:0] head_i,
  output cmd_t               cmd_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  fsm_e            state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic            out_valid_q, out_valid_d;
  rsp_t            rsp_q, rsp_d;
  logic            load;
  logic            out_free;
  logic            dump_last;
  logic [IdxW-1:0] pos_ext, cnt_ext;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign pos_ext   = IdxW'(in_req_i.position);
  assign cnt_ext   = IdxW'(cnt_q);
  assign dump_last = (idx_q == cnt_q - 1'b1);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    load        = 1'b0;
    rsp_d       = rsp_q;
    in_stall_o  = 1'b1;
    cmd_o.kind  = SH_HOLD;
    cmd_o.pos   = pos_ext;
    cmd_o.cnt   = cnt_ext;
    cmd_o.value = in_req_i.item_value;
    unique case (state_q)
      FSM_IDLE: begin
        in_stall_o = !out_free;
        if (in_valid_i && out_free) begin
          rsp_d.status    = ST_OK;
          rsp_d.element   = '0;
          rsp_d.last_flag = 1'b1;
          unique case (in_req_i.op)
            OP_INSERT: begin
              load = 1'b1;
              if (pos_ext > cnt_ext) begin
                rsp_d.status = ST_BADPOS;
              end else if (cnt_q == CntW'(DEPTH)) begin
                rsp_d.status = ST_FULL;
              end else begin
                cmd_o.kind = SH_INS;
                cnt_d      = cnt_q + 1'b1;
              end
            end
            OP_DELETE: begin
              load = 1'b1;
              if (pos_ext >= cnt_ext) begin
                rsp_d.status = ST_BADPOS;
              end else begin
                cmd_o.kind = SH_DEL;
                cnt_d      = cnt_q - 1'b1;
              end
            end
            OP_DUMP: begin
              if (cnt_q == '0) begin
                load         = 1'b1;
                rsp_d.status = ST_EMPTY;
              end else begin
                state_d = FSM_DUMP;
                idx_d   = '0;
              end
            end
            default: ;
          endcase
        end
      end
      FSM_DUMP: begin
        if (out_free) begin
          load            = 1'b1;
          rsp_d.status    = ST_OK;
          rsp_d.element   = head_i;
          rsp_d.last_flag = dump_last;
          cmd_o.kind      = SH_ROT;
          idx_d           = idx_q + 1'b1;
          if (dump_last) begin
            state_d = FSM_IDLE;
          end
        end
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  always_comb begin
    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      cnt_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

  `PLI_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= CntW'(DEPTH), "entry count above depth")
  `PLI_ASSERT_IMP(a_dump_stall, state_q == FSM_DUMP, in_stall_o, "request taken during dump")
  `PLI_ASSERT_NXT(a_ins_cnt, cmd_o.kind == SH_INS, cnt_q == $past(cnt_q) + 1'b1,
                  "insert did not grow count")
  `PLI_ASSERT_NXT(a_dump_end, state_q == FSM_DUMP && load && dump_last,
                  state_q == FSM_IDLE && out_rsp_o.last_flag, "dump did not end on last entry")

endmodule

@@ rtl/positional_list_insert_delete.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_insert_delete
// Ordered store of up to DEPTH signed values with insert, delete and dump.
// ----------------------------------------------------------------------------
// Entries sit in a row of DEPTH cells. On insert and delete the whole row
// shifts at once and one response is written to the output register, so a
// new request is taken every cycle while responses drain and the output side
// does not stall; an unused opcode is taken and gives no response. A dump
// stalls requests while it runs (one entry per cycle read from the front
// cell while the occupied cells rotate by one, while the output side does not
// stall); the row is back in order when the dump ends. A dump of an empty
// store and any rejected request give a single response. No clearing pass
// after reset.
module positional_list_insert_delete import pli_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_rsp_o
);

  cmd_t               cmd;
  logic signed [31:0] cell_data [DEPTH];

  pli_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o),
    .head_i      (cell_data[0]),
    .cmd_o       (cmd)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [31:0] left_val, right_val;

    if (i == 0) begin : g_first
      assign left_val = '0;
    end else begin : g_left
      assign left_val = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_val = '0;
    end else begin : g_right
      assign right_val = cell_data[i+1];
    end

    pli_cell #(
      .IDX (i)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .left_i  (left_val),
      .right_i (right_val),
      .head_i  (cell_data[0]),
      .data_o  (cell_data[i])
    );
  end

endmodule
